// ===== hdl/bmprgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP to RGB565 shared definitions
// Types, register indexes, reset values and color masks used by the
// pixel-data converter and its top level.
// ----------------------------------------------------------------------------
package bmprgb_pkg;

  // Largest image width or height that the converter handles.
  localparam logic [11:0] MaxDimension = 12'd4095;

  // Configuration register indexes.
  localparam logic [1:0] RegImageWidth   = 2'd0;
  localparam logic [1:0] RegImageHeight  = 2'd1;
  localparam logic [1:0] RegBytesPerPix  = 2'd2;
  localparam logic [1:0] RegMode555      = 2'd3;

  // Configuration reset values.
  localparam logic [11:0] ResetWidth     = 12'd160;
  localparam logic [11:0] ResetHeight    = 12'd128;
  localparam logic [2:0]  ResetBpp       = 3'd3;
  localparam logic        ResetMode555   = 1'b1;

  // Color field masks for truncating 24 and 32 bit pixels.
  localparam logic [15:0] GreenMask      = 16'h07E0;
  localparam logic [15:0] RedMask        = 16'hF800;

  // Active configuration as seen by the converter.
  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
    logic [2:0]  bpp;
    logic        mode_555;
  } cfg_t;

  // One converted pixel.
  typedef struct packed {
    logic        last_pixel;
    logic [11:0] row;
    logic [11:0] column;
    logic [15:0] rgb565;
  } pixel_t;

endpackage

// ===== hdl/bmprgb_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP to RGB565 pixel converter
// Holds the row and pixel counters, assembles source pixels from bytes,
// skips row padding and produces one RGB565 pixel per completed pixel.
// ----------------------------------------------------------------------------
module bmprgb_convert (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmprgb_pkg::cfg_t    cfg_i,
  input  logic                step_i,
  input  logic                new_image_i,
  input  logic [7:0]          data_byte_i,
  output logic                res_valid_o,
  output bmprgb_pkg::pixel_t  res_o
);

  // Counter state.
  logic [1:0]  byte_in_pixel_q, byte_in_pixel_d;
  logic [15:0] partial_q, partial_d;
  logic [11:0] pixel_column_q, pixel_column_d;
  logic [11:0] rows_left_q, rows_left_d;
  logic [13:0] bytes_in_row_q, bytes_in_row_d;
  logic        image_done_q, image_done_d;

  // Working values.
  logic [2:0]  bpp;
  logic [11:0] width;
  logic [11:0] height;
  logic [13:0] width_bytes;
  logic [13:0] width_round;
  logic [14:0] row_len;
  logic [1:0]  cur_bip;
  logic [15:0] cur_partial;
  logic [11:0] cur_column;
  logic [11:0] cur_rows;
  logic [13:0] cur_bytes;
  logic        cur_done;
  logic [15:0] color;
  logic [2:0]  bip_inc;
  logic        pixel_end;
  logic [14:0] bytes_inc;
  logic [12:0] column_inc;

  // Clamp the configuration and work out the padded row length.
  always_comb begin
    if (cfg_i.bpp < 3'd2) begin
      bpp = 3'd2;
    end else if (cfg_i.bpp > 3'd4) begin
      bpp = 3'd4;
    end else begin
      bpp = cfg_i.bpp;
    end
    width  = (cfg_i.width > bmprgb_pkg::MaxDimension) ? bmprgb_pkg::MaxDimension
                                                       : cfg_i.width;
    height = (cfg_i.height > bmprgb_pkg::MaxDimension) ? bmprgb_pkg::MaxDimension
                                                        : cfg_i.height;
    case (bpp)
      3'd2:    width_bytes = {1'b0, width, 1'b0};
      3'd3:    width_bytes = {1'b0, width, 1'b0} + {2'b00, width};
      default: width_bytes = {width, 2'b00};
    endcase
    width_round = width_bytes + 14'd3;
    row_len     = {1'b0, width_round[13:2], 2'b00};
  end

  // Apply a restart, then assemble the byte and advance the counters.
  always_comb begin
    if (new_image_i) begin
      cur_bip     = '0;
      cur_partial = '0;
      cur_column  = '0;
      cur_bytes   = '0;
      cur_rows    = height;
      cur_done    = (height == 12'd0);
    end else begin
      cur_bip     = byte_in_pixel_q;
      cur_partial = partial_q;
      cur_column  = pixel_column_q;
      cur_bytes   = bytes_in_row_q;
      cur_rows    = rows_left_q;
      cur_done    = image_done_q;
    end

    // Color assembly for the current byte.
    if (bpp == 3'd2) begin
      if (cur_bip == 2'd0) begin
        color = cfg_i.mode_555 ? {7'd0, data_byte_i[7:5], 1'b0, data_byte_i[4:0]}
                               : {8'd0, data_byte_i};
      end else begin
        color = cfg_i.mode_555 ? cur_partial + {data_byte_i[6:0], 9'd0}
                               : cur_partial + {data_byte_i, 8'd0};
      end
    end else begin
      case (cur_bip)
        2'd0:    color = {11'd0, data_byte_i[7:3]};
        2'd1:    color = cur_partial + ({5'd0, data_byte_i, 3'd0} & bmprgb_pkg::GreenMask);
        2'd2:    color = cur_partial + ({data_byte_i, 8'd0} & bmprgb_pkg::RedMask);
        default: color = cur_partial;
      endcase
    end

    bip_inc    = {1'b0, cur_bip} + 3'd1;
    pixel_end  = (bip_inc >= bpp);
    bytes_inc  = {1'b0, cur_bytes} + 15'd1;
    column_inc = {1'b0, cur_column} + 13'd1;

    // Result for a completed pixel inside the visible width.
    res_valid_o       = !cur_done && (cur_rows != 12'd0) && pixel_end &&
                        (cur_column < width);
    res_o.rgb565      = color;
    res_o.column      = cur_column;
    res_o.row         = cur_rows - 12'd1;
    res_o.last_pixel  = (cur_rows == 12'd1) && (column_inc == {1'b0, width});

    // Next counter state.
    byte_in_pixel_d = cur_bip;
    partial_d       = cur_partial;
    pixel_column_d  = cur_column;
    rows_left_d     = cur_rows;
    bytes_in_row_d  = cur_bytes;
    image_done_d    = cur_done;
    if (!cur_done && (cur_rows != 12'd0)) begin
      if (pixel_end) begin
        byte_in_pixel_d = '0;
        partial_d       = '0;
        if (cur_column < bmprgb_pkg::MaxDimension) begin
          pixel_column_d = column_inc[11:0];
        end
      end else begin
        byte_in_pixel_d = bip_inc[1:0];
        partial_d       = color;
      end
      if (bytes_inc >= row_len) begin
        // End of a stored row, padding included.
        rows_left_d     = cur_rows - 12'd1;
        image_done_d    = (cur_rows == 12'd1);
        pixel_column_d  = '0;
        bytes_in_row_d  = '0;
        partial_d       = '0;
        byte_in_pixel_d = '0;
      end else begin
        bytes_in_row_d = bytes_inc[13:0];
      end
    end
  end

  // State registers advance once per processed beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_in_pixel_q <= '0;
      partial_q       <= '0;
      pixel_column_q  <= '0;
      rows_left_q     <= bmprgb_pkg::ResetHeight;
      bytes_in_row_q  <= '0;
      image_done_q    <= 1'b0;
    end else if (step_i) begin
      byte_in_pixel_q <= byte_in_pixel_d;
      partial_q       <= partial_d;
      pixel_column_q  <= pixel_column_d;
      rows_left_q     <= rows_left_d;
      bytes_in_row_q  <= bytes_in_row_d;
      image_done_q    <= image_done_d;
    end
  end

endmodule

// ===== hdl/bmp_pixel_stream_to_rgb565.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP pixel stream to RGB565
// Converts bottom-up BMP pixel-data bytes of 16, 24 or 32 bit pixels into
// RGB565 pixels with column, row and a last-pixel mark.
// ----------------------------------------------------------------------------
// Path: input register, converter, then output register. Throughput: one byte beat
// per cycle while the output is not stalled; the input register holds one beat, the
// output register one pixel, and the converter handles one byte per cycle.
// Reset: configuration returns to 160 x 128, 3 bytes per pixel, RGB555 mode;
// all counters clear and the row count loads 128. No clearing pass is needed.
module bmp_pixel_stream_to_rgb565 (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [11:0] cfg_data_i,
  // Byte input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tuser,   // new_image
  // Pixel output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // pixel_rgb565[15:0], column[27:16], row[39:28]
  output logic        m_axis_tlast    // last_pixel
);

  bmprgb_pkg::cfg_t   cfg_q;
  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_new_q;
  logic               out_valid_q;
  bmprgb_pkg::pixel_t out_pixel_q;
  logic               advance;
  logic               step;
  logic               res_valid;
  bmprgb_pkg::pixel_t res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width    <= bmprgb_pkg::ResetWidth;
      cfg_q.height   <= bmprgb_pkg::ResetHeight;
      cfg_q.bpp      <= bmprgb_pkg::ResetBpp;
      cfg_q.mode_555 <= bmprgb_pkg::ResetMode555;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bmprgb_pkg::RegImageWidth:  cfg_q.width    <= cfg_data_i;
        bmprgb_pkg::RegImageHeight: cfg_q.height   <= cfg_data_i;
        bmprgb_pkg::RegBytesPerPix: cfg_q.bpp      <= cfg_data_i[2:0];
        bmprgb_pkg::RegMode555:     cfg_q.mode_555 <= cfg_data_i[0];
      endcase
    end
  end

  // The held beat moves on whenever the output register is free or drains.
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_new_q  <= s_axis_tuser;
    end
  end

  bmprgb_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (step),
    .new_image_i (in_new_q),
    .data_byte_i (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pixel_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pixel_q.row, out_pixel_q.column, out_pixel_q.rgb565};
  assign m_axis_tlast  = out_pixel_q.last_pixel;

endmodule
